// ===== src/lmpg_pkg.sv =====
// Shared types and constants of the LED matrix pattern generator.
package lmpg_pkg;

  // Field widths
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned DIM_W      = 7;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned RGB_W      = 3 * COLOR_W;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned PAL_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned LIM_W      = 3;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SELECT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STROBE_ENABLE  = 3'd4;

  // Effect modes
  localparam logic [MODE_W-1:0] MODE_PULSE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STRIP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HBAR  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_VBAR  = 2'd3;

  // Palettes
  localparam logic [PAL_W-1:0] PAL_FLAME   = 2'd0;
  localparam logic [PAL_W-1:0] PAL_GRASS   = 2'd1;
  localparam logic [PAL_W-1:0] PAL_RAINBOW = 2'd2;
  localparam logic [PAL_W-1:0] PAL_OCEAN   = 2'd3;

  // Base colour of each palette, {red, green, blue}
  localparam logic [RGB_W-1:0] PALETTE [4] = '{
    24'hFF0000, 24'h00FF00, 24'hFF00FF, 24'h0000FF
  };

  localparam logic [COLOR_W-1:0] FULL_ON = 8'hFF;

  // Strobe slot length in ms
  localparam int unsigned STROBE_SLOT_MS = 100;

  // Half widths (exclusive) of the strip dot and of the bars
  localparam logic [LIM_W-1:0] DOT_LIM = 3'd4;
  localparam logic [LIM_W-1:0] BAR_LIM = 3'd2;

  // Restoring divider for pixel index / width: steps per pipeline stage
  localparam int unsigned DIV_STEPS = 3;

  typedef struct packed {
    logic [DIM_W-1:0] rem;
    logic [IDX_W-1:0] num;
    logic [IDX_W-1:0] quo;
  } div_t;

endpackage

// ===== src/led_matrix_pattern_generator_top.sv =====
// LED matrix pattern generator: pixel colour pipeline with config registers.
//
// One pixel word enters per clock while the output is not stalled; the
// seven register stages split the frame-time modulo (a reciprocal multiply cut
// into two 16-bit partial products, then a remainder multiply), the triangle
// wave, the position products and the bound compare, while a restoring divider
// for row and column runs alongside, three quotient bits per stage. When the
// output word is not taken the whole pipeline holds, so in_ready drops only
// while a finished word waits at a stalled output. Config writes take effect
// at once; the user must make them while no word is in flight (not enforced).
module led_matrix_pattern_generator_top #(
  parameter int unsigned MAX_WIDTH       = 64,
  parameter int unsigned MAX_HEIGHT      = 64,
  parameter int unsigned PULSE_PERIOD_MS = 8000
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [lmpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lmpg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lmpg_pkg::TIME_W-1:0]      frame_ms,
  input  logic [lmpg_pkg::IDX_W-1:0]       pixel_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lmpg_pkg::IDX_W-1:0]       out_index,
  output logic [lmpg_pkg::COLOR_W-1:0]     out_red,
  output logic [lmpg_pkg::COLOR_W-1:0]     out_green,
  output logic [lmpg_pkg::COLOR_W-1:0]     out_blue
);
  import lmpg_pkg::*;

  // Loop lengths: pulse, strip, bars, strobe slot
  localparam int unsigned NDIV  = 4;
  localparam int unsigned NLOOP = 3;
  localparam int unsigned DIV0  = PULSE_PERIOD_MS;
  localparam int unsigned DIV1  = PULSE_PERIOD_MS / 2;
  localparam int unsigned DIV2  = PULSE_PERIOD_MS / 8;
  localparam int unsigned DIV3  = STROBE_SLOT_MS;
  localparam int unsigned DMAX  = (DIV0 > DIV3) ? DIV0 : DIV3;
  localparam int unsigned REM_W = $clog2(DMAX + 1);

  // Reciprocals for exact 32-bit quotient: q = (t * RCP) >> SHF
  localparam int unsigned RCP_W = TIME_W + 1;
  localparam int unsigned TH_W  = TIME_W / 2;
  localparam int unsigned PP_W  = TH_W + RCP_W;
  localparam int unsigned SUM_W = TIME_W + RCP_W;
  localparam int unsigned SHF0  = TIME_W + $clog2(DIV0);
  localparam int unsigned SHF1  = TIME_W + $clog2(DIV1);
  localparam int unsigned SHF2  = TIME_W + $clog2(DIV2);
  localparam int unsigned SHF3  = TIME_W + $clog2(DIV3);
  localparam logic [63:0] RCP0 = ((64'd1 << SHF0) + 64'(DIV0) - 64'd1) / 64'(DIV0);
  localparam logic [63:0] RCP1 = ((64'd1 << SHF1) + 64'(DIV1) - 64'd1) / 64'(DIV1);
  localparam logic [63:0] RCP2 = ((64'd1 << SHF2) + 64'(DIV2) - 64'd1) / 64'(DIV2);
  localparam logic [63:0] RCP3 = ((64'd1 << SHF3) + 64'(DIV3) - 64'd1) / 64'(DIV3);
  localparam int unsigned SHF [NDIV] = '{SHF0, SHF1, SHF2, SHF3};
  localparam logic [RCP_W-1:0] RCP [NDIV] = '{
    RCP_W'(RCP0), RCP_W'(RCP1), RCP_W'(RCP2), RCP_W'(RCP3)
  };
  localparam logic [REM_W-1:0] DIVR [NLOOP] = '{
    REM_W'(DIV0), REM_W'(DIV1), REM_W'(DIV2)
  };
  localparam logic [REM_W-1:0] HALF [NLOOP] = '{
    REM_W'(DIV0 / 2), REM_W'(DIV1 / 2), REM_W'(DIV2 / 2)
  };

  // Pulse scale: 255 * tri / half0 through an exact reciprocal
  localparam int unsigned N0    = REM_W + COLOR_W;
  localparam int unsigned S0    = N0 + $clog2(DIV0 / 2);
  localparam int unsigned M0_W  = N0 + 1;
  localparam logic [63:0] M0_FULL =
    ((64'd1 << S0) + 64'(DIV0 / 2) - 64'd1) / 64'(DIV0 / 2);
  localparam logic [M0_W-1:0] M0 = M0_W'(M0_FULL);
  localparam int unsigned PM_W  = REM_W + M0_W;
  localparam int unsigned SC_W  = PM_W + COLOR_W;

  // Position products
  localparam int unsigned SPAN_W = 2 * DIM_W;
  localparam int unsigned P_W    = SPAN_W + REM_W;

  // Config registers
  logic [MODE_W-1:0]  effect_mode;
  logic [PAL_W-1:0]   palette_select;
  logic [DIM_W-1:0]   matrix_width;
  logic [DIM_W-1:0]   matrix_height;
  logic               strobe_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode    <= MODE_PULSE;
      palette_select <= PAL_FLAME;
      matrix_width   <= DIM_W'(64);
      matrix_height  <= DIM_W'(1);
      strobe_enable  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_EFFECT_MODE:    effect_mode    <= cfg_data[MODE_W-1:0];
        REG_PALETTE_SELECT: palette_select <= cfg_data[PAL_W-1:0];
        REG_MATRIX_WIDTH:   matrix_width   <= cfg_data[DIM_W-1:0];
        REG_MATRIX_HEIGHT:  matrix_height  <= cfg_data[DIM_W-1:0];
        REG_STROBE_ENABLE:  strobe_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective dimensions: zero acts as one, oversize saturates
  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [SPAN_W-1:0] area;

  always_comb begin
    w_eff = matrix_width;
    if (matrix_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(matrix_width) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end
    h_eff = matrix_height;
    if (matrix_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(matrix_height) > MAX_HEIGHT) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end
  end

  // Pixel count, used four stages after entry
  always_ff @(posedge clk) begin
    area <= SPAN_W'(w_eff) * SPAN_W'(h_eff);
  end

  // One restoring division step: next dividend bit into the remainder
  function automatic div_t div_step(input div_t s, input logic [DIM_W-1:0] d);
    logic [DIM_W:0] trial;
    div_t r;
    trial = {s.rem, s.num[IDX_W-1]};
    r.num = s.num << 1;
    if (trial >= {1'b0, d}) begin
      r.rem = DIM_W'(trial - {1'b0, d});
      r.quo = {s.quo[IDX_W-2:0], 1'b1};
    end else begin
      r.rem = trial[DIM_W-1:0];
      r.quo = {s.quo[IDX_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic div_t div_stage(input div_t s, input logic [DIM_W-1:0] d);
    div_t r;
    r = s;
    for (int j = 0; j < DIV_STEPS; j++) begin
      r = div_step(r, d);
    end
    return r;
  endfunction

  // Pipeline advance: everything moves unless a finished word is stalled
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage a: reciprocal partial products, first divider steps
  logic                a_valid;
  logic [PP_W-1:0]     a_pp_hi [NDIV];
  logic [PP_W-1:0]     a_pp_lo [NDIV];
  logic [REM_W-1:0]    a_t_lo;
  logic [IDX_W-1:0]    a_idx;
  div_t                a_div;
  div_t                div_in;

  assign div_in = '{rem: '0, num: pixel_index, quo: '0};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NDIV; k++) begin
        a_pp_hi[k] <= PP_W'(frame_ms[TIME_W-1:TH_W]) * PP_W'(RCP[k]);
        a_pp_lo[k] <= PP_W'(frame_ms[TH_W-1:0]) * PP_W'(RCP[k]);
      end
      a_t_lo <= frame_ms[REM_W-1:0];
      a_idx  <= pixel_index;
      a_div  <= div_stage(div_in, w_eff);
    end
  end

  // Stage b: quotient low bits, strobe slot parity
  logic                b_valid;
  logic [SUM_W-1:0]    quo_b [NDIV];
  logic [REM_W-1:0]    b_qlo [NLOOP];
  logic                b_odd;
  logic [REM_W-1:0]    b_t_lo;
  logic [IDX_W-1:0]    b_idx;
  div_t                b_div;

  always_comb begin
    for (int k = 0; k < NDIV; k++) begin
      quo_b[k] = ((SUM_W'(a_pp_hi[k]) << TH_W) + SUM_W'(a_pp_lo[k])) >> SHF[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NLOOP; k++) begin
        b_qlo[k] <= quo_b[k][REM_W-1:0];
      end
      b_odd  <= quo_b[NDIV-1][0];
      b_t_lo <= a_t_lo;
      b_idx  <= a_idx;
      b_div  <= div_stage(a_div, w_eff);
    end
  end

  // Stage c: remainders t mod loop
  logic                c_valid;
  logic [REM_W-1:0]    c_rem [NLOOP];
  logic                c_odd;
  logic [IDX_W-1:0]    c_idx;
  div_t                c_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NLOOP; k++) begin
        c_rem[k] <= b_t_lo - REM_W'(b_qlo[k] * DIVR[k]);
      end
      c_odd <= b_odd;
      c_idx <= b_idx;
      c_div <= div_stage(b_div, w_eff);
    end
  end

  // Stage d: triangle waves, divider done (quo = row, rem = column)
  logic                d_valid;
  logic [REM_W-1:0]    dist_d [NLOOP];
  logic [REM_W-1:0]    d_tri [NLOOP];
  logic                d_odd;
  logic [IDX_W-1:0]    d_idx;
  div_t                d_div;

  always_comb begin
    for (int k = 0; k < NLOOP; k++) begin
      dist_d[k] = (c_rem[k] >= HALF[k]) ? (c_rem[k] - HALF[k]) : (HALF[k] - c_rem[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NLOOP; k++) begin
        d_tri[k] <= HALF[k] - dist_d[k];
      end
      d_odd <= c_odd;
      d_idx <= c_idx;
      d_div <= div_stage(c_div, w_eff);
    end
  end

  // Stage e: span * tri, pulse scale product, coordinate select
  logic                e_valid;
  logic [SPAN_W-1:0]   span_e;
  logic [REM_W-1:0]    tri_e;
  logic [IDX_W-1:0]    v_e;
  logic [P_W-1:0]      e_p;
  logic [PM_W-1:0]     e_pm;
  logic [IDX_W-1:0]    e_v;
  logic                e_odd;
  logic [IDX_W-1:0]    e_idx;

  always_comb begin
    case (effect_mode)
      MODE_HBAR: begin
        span_e = SPAN_W'(w_eff);
        tri_e  = d_tri[2];
        v_e    = IDX_W'(d_div.rem);
      end
      MODE_VBAR: begin
        span_e = SPAN_W'(h_eff);
        tri_e  = d_tri[2];
        v_e    = d_div.quo;
      end
      default: begin
        span_e = area;
        tri_e  = d_tri[1];
        v_e    = d_idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_p   <= P_W'(span_e) * P_W'(tri_e);
      e_pm  <= PM_W'(d_tri[0]) * PM_W'(M0);
      e_v   <= v_e;
      e_odd <= d_odd;
      e_idx <= d_idx;
    end
  end

  // Stage f: window bounds on span*tri, pulse level
  logic                f_valid;
  logic [REM_W-1:0]    half_f;
  logic [LIM_W-1:0]    lim_f;
  logic [SC_W-1:0]     scaled_f;
  logic [SC_W-1:0]     level_f;
  logic [P_W-1:0]      f_lb;
  logic [P_W-1:0]      f_ub;
  logic [P_W-1:0]      f_p;
  logic [COLOR_W-1:0]  f_level;
  logic                f_odd;
  logic [IDX_W-1:0]    f_idx;

  always_comb begin
    half_f   = (effect_mode == MODE_STRIP) ? HALF[1] : HALF[2];
    lim_f    = (effect_mode == MODE_STRIP) ? DOT_LIM : BAR_LIM;
    scaled_f = (SC_W'(e_pm) << COLOR_W) - SC_W'(e_pm);
    level_f  = scaled_f >> S0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // lit when (v - lim + 1) * half <= p < (v + lim) * half
      if (e_v < IDX_W'(lim_f - LIM_W'(1))) begin
        f_lb <= '0;
      end else begin
        f_lb <= P_W'(e_v - IDX_W'(lim_f - LIM_W'(1))) * P_W'(half_f);
      end
      f_ub    <= (P_W'(e_v) + P_W'(lim_f)) * P_W'(half_f);
      f_p     <= e_p;
      f_level <= level_f[COLOR_W-1:0];
      f_odd   <= e_odd;
      f_idx   <= e_idx;
    end
  end

  // Stage g: output word
  logic               lit_g;
  logic [RGB_W-1:0]   base_g;
  logic [RGB_W-1:0]   rgb_g;

  always_comb begin
    lit_g  = (f_p >= f_lb) && (f_p < f_ub);
    base_g = PALETTE[palette_select];
    if (strobe_enable && f_odd) begin
      rgb_g = {FULL_ON, FULL_ON, FULL_ON};
    end else if (effect_mode == MODE_PULSE) begin
      // base channels are all-on or off: scaled level or black
      for (int c = 0; c < 3; c++) begin
        rgb_g[c*COLOR_W +: COLOR_W] = (base_g[c*COLOR_W +: COLOR_W] != '0) ? f_level : '0;
      end
    end else begin
      rgb_g = lit_g ? base_g : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_index <= f_idx;
      out_red   <= rgb_g[2*COLOR_W +: COLOR_W];
      out_green <= rgb_g[COLOR_W +: COLOR_W];
      out_blue  <= rgb_g[0 +: COLOR_W];
    end
  end

  // A stalled output word holds the whole pipe
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // Row and column from the divider rebuild the index
  a_divider_exact: assert property (@(posedge clk) disable iff (rst)
    d_valid |-> ((20'(d_div.quo) * 20'(w_eff) + 20'(d_div.rem)) == 20'(d_idx))
                && (d_div.rem < w_eff))
    else $error("row/column split wrong");

  // Triangle values never exceed half the loop
  a_tri_range: assert property (@(posedge clk) disable iff (rst)
    d_valid |-> (d_tri[0] <= HALF[0]) && (d_tri[1] <= HALF[1]) && (d_tri[2] <= HALF[2]))
    else $error("triangle out of range");

  // Flame palette without strobe has no green or blue
  a_flame_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid && !strobe_enable && (palette_select == PAL_FLAME)
      |-> (out_green == '0) && (out_blue == '0))
    else $error("flame pixel has green or blue");

endmodule

// ===== dv/led_matrix_pattern_generator_top_tb.sv =====
// Self-checking testbench for the LED matrix pattern generator: directed table, then random phases.
module led_matrix_pattern_generator_top_tb;
  import lmpg_pkg::*;

  localparam int unsigned MAX_W       = 64;
  localparam int unsigned MAX_H       = 64;
  localparam int unsigned PERIOD_MS   = 8000;
  localparam int unsigned LATENCY     = 7;
  localparam int unsigned NUM_PHASES  = 14;
  localparam int unsigned PHASE_WORDS = 100;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PRINT_LIMIT = 60;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PAL_W-1:0]  palette;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic              strobe;
    logic [TIME_W-1:0] frame;
    logic [IDX_W-1:0]  index;
    logic              typed;
    logic [RGB_W-1:0]  rgb;
  } directed_step_t;

  // Directed rows; rgb is only used where typed is set
  localparam int unsigned NUM_DIRECTED = 20;
  directed_step_t directed_steps [NUM_DIRECTED] = '{
    '{MODE_PULSE, PAL_FLAME,   7'd64,  7'd1,   1'b0, 32'd0,          12'h000, 1'b1, 24'h000000},
    '{MODE_PULSE, PAL_FLAME,   7'd64,  7'd1,   1'b0, 32'd4000,       12'hfff, 1'b1, 24'hff0000},
    '{MODE_PULSE, PAL_GRASS,   7'd64,  7'd1,   1'b0, 32'd2000,       12'h555, 1'b1, 24'h007f00},
    '{MODE_PULSE, PAL_RAINBOW, 7'd64,  7'd1,   1'b0, 32'd8000,       12'haaa, 1'b1, 24'h000000},
    '{MODE_PULSE, PAL_OCEAN,   7'd64,  7'd1,   1'b0, 32'hffffffff,   12'h000, 1'b0, 24'h000000},
    '{MODE_PULSE, PAL_OCEAN,   7'd64,  7'd1,   1'b1, 32'd100,        12'h001, 1'b1, 24'hffffff},
    '{MODE_PULSE, PAL_OCEAN,   7'd64,  7'd1,   1'b1, 32'd200,        12'h002, 1'b0, 24'h000000},
    '{MODE_STRIP, PAL_FLAME,   7'd64,  7'd1,   1'b0, 32'd0,          12'h000, 1'b1, 24'hff0000},
    '{MODE_STRIP, PAL_FLAME,   7'd64,  7'd1,   1'b0, 32'd0,          12'h004, 1'b1, 24'h000000},
    '{MODE_STRIP, PAL_FLAME,   7'd64,  7'd1,   1'b0, 32'd0,          12'h003, 1'b1, 24'hff0000},
    '{MODE_STRIP, PAL_FLAME,   7'd64,  7'd1,   1'b0, 32'd2000,       12'h03f, 1'b0, 24'h000000},
    '{MODE_HBAR,  PAL_RAINBOW, 7'd64,  7'd64,  1'b0, 32'd500,        12'd383, 1'b0, 24'h000000},
    '{MODE_HBAR,  PAL_RAINBOW, 7'd64,  7'd64,  1'b0, 32'd0,          12'h002, 1'b1, 24'h000000},
    '{MODE_VBAR,  PAL_GRASS,   7'd0,   7'd127, 1'b0, 32'd250,        12'hfff, 1'b0, 24'h000000},
    '{MODE_VBAR,  PAL_GRASS,   7'd64,  7'd64,  1'b0, 32'd250,        12'h7c0, 1'b0, 24'h000000},
    '{MODE_STRIP, PAL_OCEAN,   7'd1,   7'd1,   1'b0, 32'd1000,       12'h000, 1'b0, 24'h000000},
    '{MODE_STRIP, PAL_OCEAN,   7'd8,   7'd8,   1'b0, 32'd1234567,    12'hfff, 1'b0, 24'h000000},
    '{MODE_HBAR,  PAL_FLAME,   7'd127, 7'd0,   1'b1, 32'd4294967199, 12'hfff, 1'b0, 24'h000000},
    '{MODE_VBAR,  PAL_FLAME,   7'd127, 7'd127, 1'b0, 32'hffffffff,   12'hfff, 1'b0, 24'h000000},
    '{MODE_PULSE, PAL_RAINBOW, 7'd64,  7'd1,   1'b0, 32'd4000,       12'h000, 1'b1, 24'hff00ff}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [TIME_W-1:0]     frame_ms = '0;
  logic [IDX_W-1:0]      pixel_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [IDX_W-1:0]      out_index;
  logic [COLOR_W-1:0]    out_red;
  logic [COLOR_W-1:0]    out_green;
  logic [COLOR_W-1:0]    out_blue;

  // Typed expectation that rides along with the word on the input
  logic                  word_typed = 1'b0;
  logic [RGB_W-1:0]      word_rgb = '0;

  // Mirror of the config registers
  logic [MODE_W-1:0]     cur_mode;
  logic [PAL_W-1:0]      cur_palette;
  logic [DIM_W-1:0]      cur_width;
  logic [DIM_W-1:0]      cur_height;
  logic                  cur_strobe;

  pixel_t                expected_pixels [$];
  idle_mode_t            idle_mode = IDLE_NONE;
  int unsigned           mismatches = 0;
  int unsigned           cycles = 0;

  led_matrix_pattern_generator_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .frame_ms    (frame_ms),
    .pixel_index (pixel_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_index   (out_index),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Triangle wave in [0, loop/2]
  function automatic longint unsigned tri_wave(logic [TIME_W-1:0] t, longint unsigned loop_ms);
    longint unsigned half;
    longint unsigned adv;
    longint unsigned d;
    half = loop_ms / 2;
    adv  = t % loop_ms;
    d    = (adv >= half) ? adv - half : half - adv;
    return half - d;
  endfunction

  function automatic logic [RGB_W-1:0] base_color(logic [PAL_W-1:0] pal);
    case (pal)
      PAL_FLAME:   return 24'hff0000;
      PAL_GRASS:   return 24'h00ff00;
      PAL_RAINBOW: return 24'hff00ff;
      default:     return 24'h0000ff;
    endcase
  endfunction

  function automatic pixel_t predict_pixel(logic [TIME_W-1:0] t, logic [IDX_W-1:0] idx);
    longint unsigned w, h, loop_ms, span, v, lim, pos, d, half;
    logic [RGB_W-1:0] base;
    pixel_t p;
    w    = eff_dim(cur_width, MAX_W);
    h    = eff_dim(cur_height, MAX_H);
    base = base_color(cur_palette);
    p    = '{index: idx, red: '0, green: '0, blue: '0};
    if (cur_mode == MODE_PULSE) begin
      half    = PERIOD_MS / 2;
      d       = tri_wave(t, PERIOD_MS);
      p.red   = 8'(base[23:16] * d / half);
      p.green = 8'(base[15:8] * d / half);
      p.blue  = 8'(base[7:0] * d / half);
    end else begin
      case (cur_mode)
        MODE_STRIP: begin
          loop_ms = PERIOD_MS / 2;
          span    = w * h;
          v       = idx;
          lim     = 4;
        end
        MODE_HBAR: begin
          loop_ms = PERIOD_MS / 8;
          span    = w;
          v       = idx % w;
          lim     = 2;
        end
        default: begin
          loop_ms = PERIOD_MS / 8;
          span    = h;
          v       = idx / w;
          lim     = 2;
        end
      endcase
      pos = span * tri_wave(t, loop_ms) / (loop_ms / 2);
      d   = (pos >= v) ? pos - v : v - pos;
      if (d < lim) {p.red, p.green, p.blue} = base;
    end
    // strobe overlay in odd 100 ms slots
    if (cur_strobe && ((t / 100) % 2 == 1)) {p.red, p.green, p.blue} = 24'hffffff;
    return p;
  endfunction

  // ---------------------------------------------------------------- checker

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch %s: got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  // Config mirror, expectation store and output compare
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      cur_mode    <= MODE_PULSE;
      cur_palette <= PAL_FLAME;
      cur_width   <= 7'd64;
      cur_height  <= 7'd1;
      cur_strobe  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected word, index", out_index, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_index !== want.index) report_mismatch("index", out_index, want.index);
          if (out_red !== want.red)     report_mismatch("red", out_red, want.red);
          if (out_green !== want.green) report_mismatch("green", out_green, want.green);
          if (out_blue !== want.blue)   report_mismatch("blue", out_blue, want.blue);
        end
      end
      if (in_valid && in_ready) begin
        if (word_typed) begin
          want.index = pixel_index;
          {want.red, want.green, want.blue} = word_rgb;
        end else begin
          want = predict_pixel(frame_ms, pixel_index);
        end
        expected_pixels.push_back(want);
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_EFFECT_MODE:    cur_mode    <= cfg_data[MODE_W-1:0];
          REG_PALETTE_SELECT: cur_palette <= cfg_data[PAL_W-1:0];
          REG_MATRIX_WIDTH:   cur_width   <= cfg_data[DIM_W-1:0];
          REG_MATRIX_HEIGHT:  cur_height  <= cfg_data[DIM_W-1:0];
          REG_STROBE_ENABLE:  cur_strobe  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  function automatic bit sender_pause();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 75;
      IDLE_BOTH: return $urandom_range(99) < 22;
      default:   return 1'b0;
    endcase
  endfunction

  // Receiver back-pressure
  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECV: out_ready <= $urandom_range(99) >= 75;
      IDLE_BOTH: out_ready <= $urandom_range(99) >= 22;
      default:   out_ready <= 1'b1;
    endcase
  end

  task automatic send_pixel(logic [TIME_W-1:0] t, logic [IDX_W-1:0] idx,
                            logic typed, logic [RGB_W-1:0] rgb);
    while (sender_pause()) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    frame_ms    <= t;
    pixel_index <= idx;
    word_typed  <= typed;
    word_rgb    <= rgb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Stop sending and let every word in flight come out
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(5))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return 7'($urandom_range(65, 127));
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  initial begin
    directed_step_t   row;
    logic [MODE_W-1:0] mode;
    logic [PAL_W-1:0]  pal;
    logic [DIM_W-1:0]  w, h;
    logic              strobe;
    logic [TIME_W-1:0] t;
    logic [IDX_W-1:0]  idx;
    int unsigned       pixels;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table; registers change only with the pipeline empty
    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      if (row.mode != cur_mode || row.palette != cur_palette || row.width != cur_width ||
          row.height != cur_height || row.strobe != cur_strobe) begin
        drain_pipeline();
        if (row.mode != cur_mode)       write_reg(REG_EFFECT_MODE, 7'(row.mode));
        if (row.palette != cur_palette) write_reg(REG_PALETTE_SELECT, 7'(row.palette));
        if (row.width != cur_width)     write_reg(REG_MATRIX_WIDTH, row.width);
        if (row.height != cur_height)   write_reg(REG_MATRIX_HEIGHT, row.height);
        if (row.strobe != cur_strobe)   write_reg(REG_STROBE_ENABLE, 7'(row.strobe));
      end
      send_pixel(row.frame, row.index, row.typed, row.rgb);
    end

    // Random phases: first few pin the size extremes, the rest are random
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin mode = MODE_PULSE; w = 7'd0;   h = 7'd0;   strobe = 1'b0; end
        1: begin mode = MODE_STRIP; w = 7'd127; h = 7'd127; strobe = 1'b1; end
        2: begin mode = MODE_HBAR;  w = 7'd64;  h = 7'd64;  strobe = 1'b0; end
        3: begin mode = MODE_VBAR;  w = 7'd1;   h = 7'd64;  strobe = 1'b1; end
        4: begin mode = MODE_STRIP; w = 7'd1;   h = 7'd1;   strobe = 1'b0; end
        default: begin
          mode   = MODE_W'($urandom_range(3));
          w      = pick_dim();
          h      = pick_dim();
          strobe = 1'($urandom_range(1));
        end
      endcase
      pal = PAL_W'(p);
      drain_pipeline();
      idle_mode = idle_mode_t'(p % 4);
      // upper data bits are don't-care for the narrow registers
      write_reg(REG_EFFECT_MODE, 7'(mode) | 7'($urandom_range(31) << MODE_W));
      write_reg(REG_PALETTE_SELECT, 7'(pal) | 7'($urandom_range(31) << PAL_W));
      write_reg(REG_MATRIX_WIDTH, w);
      write_reg(REG_MATRIX_HEIGHT, h);
      write_reg(REG_STROBE_ENABLE, 7'(strobe) | 7'($urandom_range(63) << 1));
      pixels = int'(eff_dim(w, MAX_W) * eff_dim(h, MAX_H));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: t = 32'(20 * $urandom_range(20000));
          6, 7:             t = $urandom();
          8:                t = 32'hffffffff - 32'($urandom_range(20000));
          default:          t = 32'($urandom_range(20000));
        endcase
        if ($urandom_range(99) < 85) idx = IDX_W'($urandom_range(pixels - 1));
        else                         idx = IDX_W'($urandom_range(4095));
        send_pixel(t, idx, 1'b0, '0);
      end
    end

    drain_pipeline();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
